// ----- hw/rtl/smtp_seq_pkg.sv -----
package smtp_seq_pkg;

  // event kinds
  localparam logic [1:0] CMD_OPEN = 2'd0;
  localparam logic [1:0] CMD_TICK = 2'd1;
  localparam logic [1:0] CMD_LINE = 2'd2;

  // first word of a command line
  localparam logic [3:0] VERB_EHLO     = 4'd0;
  localparam logic [3:0] VERB_HELO     = 4'd1;
  localparam logic [3:0] VERB_STARTTLS = 4'd2;
  localparam logic [3:0] VERB_AUTH     = 4'd3;
  localparam logic [3:0] VERB_MAIL     = 4'd4;
  localparam logic [3:0] VERB_RCPT     = 4'd5;
  localparam logic [3:0] VERB_DATA     = 4'd6;
  localparam logic [3:0] VERB_QUIT     = 4'd7;
  localparam logic [3:0] VERB_RSET     = 4'd8;
  localparam logic [3:0] VERB_NOOP     = 4'd9;

  // reply numbers
  localparam logic [9:0] RC_220 = 10'd220;
  localparam logic [9:0] RC_221 = 10'd221;
  localparam logic [9:0] RC_235 = 10'd235;
  localparam logic [9:0] RC_250 = 10'd250;
  localparam logic [9:0] RC_354 = 10'd354;
  localparam logic [9:0] RC_421 = 10'd421;
  localparam logic [9:0] RC_451 = 10'd451;
  localparam logic [9:0] RC_454 = 10'd454;
  localparam logic [9:0] RC_500 = 10'd500;
  localparam logic [9:0] RC_502 = 10'd502;
  localparam logic [9:0] RC_503 = 10'd503;
  localparam logic [9:0] RC_530 = 10'd530;
  localparam logic [9:0] RC_535 = 10'd535;
  localparam logic [9:0] RC_552 = 10'd552;

  // EHLO capability lines
  localparam logic [3:0] CAP_NONE     = 4'd0;
  localparam logic [3:0] CAP_STARTTLS = 4'd6;
  localparam logic [3:0] CAP_AUTH     = 4'd7;
  localparam logic [3:0] CAP_HELP     = 4'd8;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_TLS_REQUIRED      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STARTTLS_REQUIRED = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COMMAND_TIMEOUT   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_MESSAGE_SIZE  = 2'd3;

  localparam logic [10:0] MAX_LINE          = 11'd1024;
  localparam logic [16:0] CONNECT_TIMEOUT_S = 17'd60;
  localparam logic [16:0] IDLE_MAX          = 17'd131071;

  typedef struct packed {
    logic        tls_required;
    logic        starttls_required;
    logic [15:0] command_timeout_s;
    logic [31:0] max_message_size;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  command;
    logic [3:0]  verb;
    logic [10:0] line_length;
    logic        leading_dot;
    logic        lone_dot;
    logic        conn_allowed;
    logic        auth_ok;
    logic        tls_ok;
    logic        store_ok;
  } item_t;

  // reply plan handed from the front to the back
  typedef enum logic [1:0] {
    PLAN_ONE,   // one reply: code, closed
    PLAN_PAIR,  // 220, then code with closed
    PLAN_EHLO   // seven 250 capability lines
  } plan_kind_t;

  typedef struct packed {
    plan_kind_t  kind;
    logic [9:0]  code;
    logic        closed;
    logic        tls;
  } plan_t;

  typedef struct packed {
    logic  valid;
    plan_t plan;
  } head_t;

endpackage

// ----- hw/rtl/smtp_seq_front.sv -----
module smtp_seq_front import smtp_seq_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  cfg_t  cfg,
  input  logic  fire,
  input  item_t item,
  output logic  push,
  output plan_t plan
);

  typedef enum logic [2:0] {
    ST_CONNECTED = 3'd0,
    ST_GREETED   = 3'd1,
    ST_AUTHED    = 3'd2,
    ST_MAIL      = 3'd3,
    ST_RCPT      = 3'd4
  } sess_state_t;

  sess_state_t state_r, state_nxt;
  logic        tls_r, tls_nxt;
  logic        auth_r, auth_nxt;
  logic        rcpt_r, rcpt_nxt;
  logic        data_r, data_nxt;
  logic [32:0] bytes_r, bytes_nxt;
  logic [16:0] idle_r, idle_nxt;
  logic        closed_r, closed_nxt;

  logic [10:0] len_adj;
  logic [32:0] bytes_sum;
  logic [16:0] limit;
  logic        tls_miss;

  assign len_adj   = (item.leading_dot && item.line_length != 11'd0) ?
                     item.line_length - 11'd1 : item.line_length;
  assign bytes_sum = bytes_r + {22'd0, len_adj} + 33'd2;
  assign limit     = (state_r == ST_CONNECTED) ? CONNECT_TIMEOUT_S :
                     {1'b0, cfg.command_timeout_s};
  assign tls_miss  = cfg.tls_required && !tls_r;

  always_comb begin
    state_nxt  = state_r;
    tls_nxt    = tls_r;
    auth_nxt   = auth_r;
    rcpt_nxt   = rcpt_r;
    data_nxt   = data_r;
    bytes_nxt  = bytes_r;
    idle_nxt   = idle_r;
    closed_nxt = closed_r;
    push       = 1'b0;
    plan.kind  = PLAN_ONE;
    plan.code  = RC_250;
    plan.closed = 1'b0;
    plan.tls   = tls_r;

    if (item.command == CMD_OPEN) begin
      state_nxt  = ST_CONNECTED;
      tls_nxt    = 1'b0;
      auth_nxt   = 1'b0;
      rcpt_nxt   = 1'b0;
      data_nxt   = 1'b0;
      bytes_nxt  = '0;
      idle_nxt   = '0;
      push       = 1'b1;
      plan.tls   = 1'b0;
      if (item.conn_allowed) begin
        plan.code  = RC_220;
        closed_nxt = 1'b0;
      end else begin
        plan.kind   = PLAN_PAIR;
        plan.code   = RC_421;
        plan.closed = 1'b1;
        closed_nxt  = 1'b1;
      end
    end else if (item.command == CMD_TICK) begin
      if (idle_r != IDLE_MAX) idle_nxt = idle_r + 17'd1;
    end else if (item.command == CMD_LINE && !closed_r) begin
      if (item.line_length > MAX_LINE) begin
        push        = 1'b1;
        plan.code   = RC_500;
        plan.closed = 1'b1;
        closed_nxt  = 1'b1;
        data_nxt    = 1'b0;
      end else if (data_r) begin
        if (item.lone_dot) begin
          push      = 1'b1;
          plan.code = item.store_ok ? RC_250 : RC_451;
          data_nxt  = 1'b0;
          state_nxt = ST_MAIL;
          rcpt_nxt  = 1'b0;
        end else begin
          bytes_nxt = bytes_sum;
          if (bytes_sum > {1'b0, cfg.max_message_size}) begin
            push      = 1'b1;
            plan.code = RC_552;
            data_nxt  = 1'b0;
            state_nxt = ST_MAIL;
            rcpt_nxt  = 1'b0;
          end
        end
      end else if (item.line_length != 11'd0) begin
        push = 1'b1;
        if (idle_r > limit) begin
          plan.code   = RC_421;
          plan.closed = 1'b1;
          closed_nxt  = 1'b1;
        end else begin
          idle_nxt = '0;
          unique case (item.verb)
            VERB_EHLO: begin
              plan.kind = PLAN_EHLO;
              state_nxt = ST_GREETED;
            end
            VERB_HELO: state_nxt = ST_GREETED;
            VERB_STARTTLS: begin
              if (state_r == ST_CONNECTED) begin
                plan.code = RC_503;
              end else if (tls_r) begin
                plan.code = RC_454;
              end else if (item.tls_ok) begin
                plan.code = RC_220;
                tls_nxt   = 1'b1;
                auth_nxt  = 1'b0;
                rcpt_nxt  = 1'b0;
              end else begin
                plan.kind   = PLAN_PAIR;
                plan.code   = RC_454;
                plan.closed = 1'b1;
                closed_nxt  = 1'b1;
              end
            end
            VERB_AUTH: begin
              if (state_r == ST_CONNECTED) begin
                plan.code = RC_503;
              end else if (cfg.starttls_required && !tls_r) begin
                plan.code = RC_530;
              end else if (auth_r) begin
                plan.code = RC_503;
                state_nxt = ST_AUTHED;
              end else if (item.auth_ok) begin
                plan.code = RC_235;
                auth_nxt  = 1'b1;
                state_nxt = ST_AUTHED;
              end else begin
                plan.code = RC_535;
              end
            end
            VERB_MAIL: begin
              if (state_r == ST_CONNECTED) begin
                plan.code = RC_503;
              end else if (tls_miss || !auth_r) begin
                plan.code = RC_530;
              end else begin
                rcpt_nxt  = 1'b0;
                state_nxt = ST_MAIL;
              end
            end
            VERB_RCPT: begin
              if (state_r != ST_MAIL && state_r != ST_RCPT) begin
                plan.code = RC_503;
              end else if (tls_miss) begin
                plan.code = RC_530;
              end else begin
                rcpt_nxt  = 1'b1;
                state_nxt = ST_RCPT;
              end
            end
            VERB_DATA: begin
              if (state_r != ST_RCPT) begin
                plan.code = RC_503;
              end else if (tls_miss) begin
                plan.code = RC_530;
              end else if (!rcpt_r) begin
                plan.code = RC_503;
                state_nxt = ST_MAIL;
              end else begin
                plan.code = RC_354;
                data_nxt  = 1'b1;
                bytes_nxt = '0;
                state_nxt = ST_MAIL;
              end
            end
            VERB_QUIT: begin
              plan.code   = RC_221;
              plan.closed = 1'b1;
              closed_nxt  = 1'b1;
            end
            VERB_RSET: begin
              auth_nxt  = 1'b0;
              rcpt_nxt  = 1'b0;
              state_nxt = ST_GREETED;
            end
            VERB_NOOP: plan.code = RC_250;
            default:   plan.code = RC_502;
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_CONNECTED;
      tls_r    <= 1'b0;
      auth_r   <= 1'b0;
      rcpt_r   <= 1'b0;
      data_r   <= 1'b0;
      bytes_r  <= '0;
      idle_r   <= '0;
      closed_r <= 1'b0;
    end else if (fire) begin
      state_r  <= state_nxt;
      tls_r    <= tls_nxt;
      auth_r   <= auth_nxt;
      rcpt_r   <= rcpt_nxt;
      data_r   <= data_nxt;
      bytes_r  <= bytes_nxt;
      idle_r   <= idle_nxt;
      closed_r <= closed_nxt;
    end
  end

`ifndef SYNTHESIS
  a_tls_after_greeting: assert property (@(posedge clk) disable iff (!rst_n)
    tls_r |-> state_r != ST_CONNECTED)
    else $error("TLS active before greeting");
  a_data_in_mail: assert property (@(posedge clk) disable iff (!rst_n)
    data_r |-> state_r == ST_MAIL && !closed_r)
    else $error("data phase outside mail state");
  a_closed_sticks: assert property (@(posedge clk) disable iff (!rst_n)
    closed_r && !(fire && item.command == CMD_OPEN) |=> closed_r)
    else $error("session reopened without open event");
`endif

endmodule

// ----- hw/rtl/smtp_seq_queue.sv -----
module smtp_seq_queue import smtp_seq_pkg::*; #(
  parameter int unsigned DEPTH = 4
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  plan_t push_plan,
  input  logic  pop,
  output logic  full,
  output head_t head
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);

  plan_t           mem_r [DEPTH];
  logic [AW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]   count_r;

  assign full       = (count_r == CW'(DEPTH));
  assign head.valid = (count_r != '0);
  assign head.plan  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_plan;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= (wr_ptr_r == LAST_SLOT) ? '0 : wr_ptr_r + AW'(1);
      if (pop)  rd_ptr_r <= (rd_ptr_r == LAST_SLOT) ? '0 : rd_ptr_r + AW'(1);
      if (push && !pop)      count_r <= count_r + CW'(1);
      else if (pop && !push) count_r <= count_r - CW'(1);
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && full && !pop))
    else $error("plan queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> head.valid)
    else $error("plan queue underflow");
  a_count_moves: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> count_r == $past(count_r) + CW'(1))
    else $error("plan queue count lost a push");
`endif

endmodule

// ----- hw/rtl/smtp_seq_back.sv -----
module smtp_seq_back import smtp_seq_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  head_t       head,
  output logic        pop,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [9:0]  reply_code,
  output logic [3:0]  capability,
  output logic        session_closed,
  output logic        out_tlast
);

  logic [2:0] step_r;
  logic       out_valid_r;
  logic [9:0] code_r;
  logic [3:0] cap_r;
  logic       closed_r, last_r;

  logic [9:0] line_code;
  logic [3:0] line_cap;
  logic       line_closed, line_end, load;

  always_comb begin
    line_code   = RC_250;
    line_cap    = CAP_NONE;
    line_closed = 1'b0;
    line_end    = 1'b1;
    unique case (head.plan.kind)
      PLAN_ONE: begin
        line_code   = head.plan.code;
        line_closed = head.plan.closed;
      end
      PLAN_PAIR: begin
        if (step_r == 3'd0) begin
          line_code = RC_220;
          line_end  = 1'b0;
        end else begin
          line_code   = head.plan.code;
          line_closed = head.plan.closed;
        end
      end
      PLAN_EHLO: begin
        line_end = (step_r == 3'd6);
        if (step_r == 3'd6)      line_cap = CAP_HELP;
        else if (step_r == 3'd5) line_cap = head.plan.tls ? CAP_AUTH : CAP_STARTTLS;
        else                     line_cap = {1'b0, step_r} + 4'd1;
      end
      default: ;
    endcase
  end

  assign load = head.valid && (!out_valid_r || out_tready);
  assign pop  = load && line_end;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      step_r      <= '0;
    end else if (load) begin
      out_valid_r <= 1'b1;
      step_r      <= line_end ? 3'd0 : step_r + 3'd1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      code_r   <= line_code;
      cap_r    <= line_cap;
      closed_r <= line_closed;
      last_r   <= line_end;
    end
  end

  assign out_tvalid     = out_valid_r;
  assign reply_code     = code_r;
  assign capability     = cap_r;
  assign session_closed = closed_r;
  assign out_tlast      = last_r;

`ifndef SYNTHESIS
  a_step_holds_plan: assert property (@(posedge clk) disable iff (!rst_n)
    step_r != 3'd0 |-> head.valid && head.plan.kind != PLAN_ONE)
    else $error("run in progress without its plan");
  a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    head.valid && head.plan.kind == PLAN_PAIR |-> step_r <= 3'd1)
    else $error("pair run past its second line");
  a_closed_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && closed_r |-> last_r)
    else $error("closing reply not at end of run");
`endif

endmodule

// ----- hw/rtl/smtp_session_sequencer_unit.sv -----
// Server side of one SMTP session. Events arrive on the in_ channel: open,
// one-second tick or a pre-classified received line; each accepted event
// updates the session state in the cycle it is taken, and any replies it
// causes are queued as a compact plan. The out_ channel then streams reply
// lines one per ready cycle, out_tlast on the final line of each event:
// most events give one line, a refused open or a failed STARTTLS gives two,
// EHLO gives seven 250 capability lines. Input is taken every cycle while
// the plan queue (QUEUE_DEPTH events) has room, so the sustained rate is
// bounded by the output port at one reply line per cycle. Configuration
// writes on the cfg_ channel are always ready and must be made while idle.
module smtp_session_sequencer_unit import smtp_seq_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  // [3:0] verb, [14:4] line_length, [15] leading_dot, [16] lone_dot,
  // [17] conn_allowed, [18] auth_ok, [19] tls_ok, [20] store_ok, [23:21] zero
  input  logic [23:0]          in_tdata,
  // [1:0] command
  input  logic [1:0]           in_tuser,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  // [9:0] reply_code, [13:10] capability, [14] session_closed, [15] zero
  output logic [15:0]          out_tdata,
  output logic                 out_tlast,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data
);

  cfg_t  cfg_r;
  item_t item;
  plan_t plan;
  head_t head;
  logic  push, pop, q_full, fire;
  logic [9:0] reply_code;
  logic [3:0] capability;
  logic       session_closed;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.tls_required      <= 1'b0;
      cfg_r.starttls_required <= 1'b0;
      cfg_r.command_timeout_s <= 16'd300;
      cfg_r.max_message_size  <= 32'd10485760;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_TLS_REQUIRED:      cfg_r.tls_required      <= cfg_data[0];
        CFG_STARTTLS_REQUIRED: cfg_r.starttls_required <= cfg_data[0];
        CFG_COMMAND_TIMEOUT:   cfg_r.command_timeout_s <= cfg_data[15:0];
        CFG_MAX_MESSAGE_SIZE:  cfg_r.max_message_size  <= cfg_data;
        default: ;
      endcase
    end
  end

  assign item.command      = in_tuser;
  assign item.verb         = in_tdata[3:0];
  assign item.line_length  = in_tdata[14:4];
  assign item.leading_dot  = in_tdata[15];
  assign item.lone_dot     = in_tdata[16];
  assign item.conn_allowed = in_tdata[17];
  assign item.auth_ok      = in_tdata[18];
  assign item.tls_ok       = in_tdata[19];
  assign item.store_ok     = in_tdata[20];

  assign in_tready = !q_full;
  assign fire      = in_tvalid && in_tready;

  smtp_seq_front u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (cfg_r),
    .fire  (fire),
    .item  (item),
    .push  (push),
    .plan  (plan)
  );

  smtp_seq_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (fire && push),
    .push_plan (plan),
    .pop       (pop),
    .full      (q_full),
    .head      (head)
  );

  smtp_seq_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .head           (head),
    .pop            (pop),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .reply_code     (reply_code),
    .capability     (capability),
    .session_closed (session_closed),
    .out_tlast      (out_tlast)
  );

  assign out_tdata = {1'b0, session_closed, capability, reply_code};

endmodule
